### src/vehicle_pi_speed_and_steer_control_assert.svh
// Assertion macros for the vehicle PI speed and steering controller.
// Both macros sample on the rising edge of clk and are off while rst_n is low.
`ifndef VEHICLE_PI_SPEED_AND_STEER_CONTROL_ASSERT_SVH
`define VEHICLE_PI_SPEED_AND_STEER_CONTROL_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define VPSSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define VPSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VPSSC_ASSERT(label, prop, msg)
`define VPSSC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### src/vpssc_pkg.sv
`timescale 1ns / 1ps

package vpssc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_W      = 24;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 48;

    localparam int GAIN_W  = 23;
    localparam int LIMIT_W = 24;
    localparam int DT_W    = 16;
    localparam int SPEED_W = 24;
    localparam int ANG_W   = 21;
    localparam int SUM_W   = 25;
    localparam int STEER_W = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_MIN    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUM_LIMIT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_AIM_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEF  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD  = 3'd6;

    // Internal widths of the shared datapath.
    localparam int DV_W     = SPEED_W + 1;
    localparam int ANGX_W   = ANG_W + 1;
    localparam int MA_W     = GAIN_W + 1;
    localparam int CMD_W    = 2 * SPEED_W + 3 - FRAC_BITS;
    localparam int INC_W    = DT_W + DV_W - FRAC_BITS;
    localparam int UNF_W    = MA_W + ANGX_W - 1 - FRAC_BITS;
    localparam int DIFF_W   = ((UNF_W > STEER_W) ? UNF_W : STEER_W) + 1;
    localparam int RATE_W   = DIFF_W + GAIN_W - FRAC_BITS;
    localparam int MB_A     = (DIFF_W > INC_W) ? DIFF_W : INC_W;
    localparam int MB_W     = (MB_A > DV_W) ? MB_A : DV_W;
    localparam int RL_W     = MB_W - 1;
    localparam int RATE_X_W = (RATE_W > RL_W) ? RATE_W : RL_W + 1;
    localparam int RH_W     = RATE_X_W - RL_W;
    localparam int PROD_W   = MA_W + MB_W;
    localparam int ACC_W    = RATE_X_W + DT_W + 1;
    localparam int S_W      = (((ACC_W - FRAC_BITS) > STEER_W) ? ACC_W - FRAC_BITS : STEER_W) + 1;
    localparam int SUMX_W   = ((INC_W > SUM_W) ? INC_W : SUM_W) + 1;

    // Angle constants, rounded to nearest at FRAC_BITS.
    localparam longint PI_Q30 = 64'sd3373259426;
    localparam longint PI1_Q  = (PI_Q30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint PI2_Q  = (PI_Q30 * 2 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint PI3_Q  = (PI_Q30 * 3 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
    localparam longint K93_Q  = ((64'sd93 <<< FRAC_BITS) * 2 + 10) / 20;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MUL_KP,
        ST_ACC_KP,
        ST_MUL_KIS,
        ST_ACC_KIS,
        ST_MUL_DT,
        ST_ACC_DT,
        ST_MUL_KII,
        ST_ACC_KII,
        ST_MUL_AIM,
        ST_ACC_AIM,
        ST_MUL_COEF,
        ST_ACC_COEF,
        ST_MUL_RLO,
        ST_ACC_RLO,
        ST_MUL_RHI,
        ST_ACC_RHI,
        ST_FINISH
    } state_t;

    typedef enum logic [2:0] {
        SEL_KP_DV,
        SEL_KI_SUM,
        SEL_DT_DV,
        SEL_KI_INC,
        SEL_AIM_ANG,
        SEL_COEF_DIFF,
        SEL_DT_RLO,
        SEL_DT_RHI
    } mul_sel_t;

    typedef enum logic [3:0] {
        ACC_NONE,
        ACC_KP,
        ACC_KIS,
        ACC_INC,
        ACC_KII,
        ACC_UNF,
        ACC_RATE,
        ACC_RLO,
        ACC_RHI,
        ACC_FINISH
    } acc_op_t;

    typedef struct packed {
        logic     load;
        mul_sel_t mul_sel;
        acc_op_t  acc;
    } dp_cmd_t;

    typedef struct packed {
        logic in_limits;
        logic out_free;
    } dp_status_t;

endpackage

### src/vpssc_ctrl.sv
`timescale 1ns / 1ps

module vpssc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  vpssc_pkg::dp_status_t status,
    output vpssc_pkg::dp_cmd_t    cmd
);
    import vpssc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_KP;
                end
            end
            ST_MUL_KP:   state_next = ST_ACC_KP;
            ST_ACC_KP:   state_next = ST_MUL_KIS;
            ST_MUL_KIS:  state_next = ST_ACC_KIS;
            ST_ACC_KIS:  state_next = ST_MUL_DT;
            ST_MUL_DT:   state_next = ST_ACC_DT;
            ST_ACC_DT:   state_next = status.in_limits ? ST_MUL_KII : ST_MUL_AIM;
            ST_MUL_KII:  state_next = ST_ACC_KII;
            ST_ACC_KII:  state_next = ST_MUL_AIM;
            ST_MUL_AIM:  state_next = ST_ACC_AIM;
            ST_ACC_AIM:  state_next = ST_MUL_COEF;
            ST_MUL_COEF: state_next = ST_ACC_COEF;
            ST_ACC_COEF: state_next = ST_MUL_RLO;
            ST_MUL_RLO:  state_next = ST_ACC_RLO;
            ST_ACC_RLO:  state_next = ST_MUL_RHI;
            ST_MUL_RHI:  state_next = ST_ACC_RHI;
            ST_ACC_RHI:  state_next = ST_FINISH;
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.load    = 1'b0;
        cmd.mul_sel = SEL_KP_DV;
        cmd.acc     = ACC_NONE;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MUL_KP:   cmd.mul_sel = SEL_KP_DV;
            ST_ACC_KP:   cmd.acc     = ACC_KP;
            ST_MUL_KIS:  cmd.mul_sel = SEL_KI_SUM;
            ST_ACC_KIS:  cmd.acc     = ACC_KIS;
            ST_MUL_DT:   cmd.mul_sel = SEL_DT_DV;
            ST_ACC_DT:   cmd.acc     = ACC_INC;
            ST_MUL_KII:  cmd.mul_sel = SEL_KI_INC;
            ST_ACC_KII:  cmd.acc     = ACC_KII;
            ST_MUL_AIM:  cmd.mul_sel = SEL_AIM_ANG;
            ST_ACC_AIM:  cmd.acc     = ACC_UNF;
            ST_MUL_COEF: cmd.mul_sel = SEL_COEF_DIFF;
            ST_ACC_COEF: cmd.acc     = ACC_RATE;
            ST_MUL_RLO:  cmd.mul_sel = SEL_DT_RLO;
            ST_ACC_RLO:  cmd.acc     = ACC_RLO;
            ST_MUL_RHI:  cmd.mul_sel = SEL_DT_RHI;
            ST_ACC_RHI:  cmd.acc     = ACC_RHI;
            ST_FINISH:   cmd.acc     = ACC_FINISH;
        endcase
    end

endmodule

### src/vpssc_datapath.sv
`timescale 1ns / 1ps

module vpssc_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  vpssc_pkg::dp_cmd_t                    cmd,
    output vpssc_pkg::dp_status_t                 status,
    input  logic                                  cfg_we,
    input  logic [vpssc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vpssc_pkg::CFG_W-1:0]           cfg_data,
    input  logic signed [vpssc_pkg::SPEED_W-1:0]  measured_speed,
    input  logic signed [vpssc_pkg::SPEED_W-1:0]  speed_target,
    input  logic signed [vpssc_pkg::SPEED_W-1:0]  accel_feedforward,
    input  logic                                  integral_off,
    input  logic signed [vpssc_pkg::ANG_W-1:0]    heading_error,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic signed [vpssc_pkg::LIMIT_W-1:0]  accel_command,
    output logic signed [vpssc_pkg::STEER_W-1:0]  steer_angle,
    output logic                                  accel_clamped
);
    import vpssc_pkg::*;

    localparam logic signed [ANGX_W-1:0] PI1_A = ANGX_W'(PI1_Q);
    localparam logic signed [ANGX_W-1:0] PI2_A = ANGX_W'(PI2_Q);
    localparam logic signed [S_W-1:0]    PI3_S = S_W'(PI3_Q);
    localparam logic signed [S_W-1:0]    K93_S = S_W'(K93_Q);

    logic [GAIN_W-1:0]         speed_gain_reg;
    logic signed [LIMIT_W-1:0] accel_max_reg;
    logic signed [LIMIT_W-1:0] accel_min_reg;
    logic [GAIN_W-1:0]         sum_limit_reg;
    logic [GAIN_W-1:0]         aim_gain_reg;
    logic [GAIN_W-1:0]         filter_coef_reg;
    logic [DT_W-1:0]           tick_period_reg;

    logic signed [DV_W-1:0]    dv_reg;
    logic signed [ANGX_W-1:0]  ang_reg;
    logic                      ioff_reg;
    logic signed [CMD_W-1:0]   cmd_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [INC_W-1:0]   inc_reg;
    logic                      inside_reg;
    logic signed [DIFF_W-1:0]  diff_reg;
    logic signed [RATE_W-1:0]  rate_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [STEER_W-1:0] steer_reg;
    logic                      out_valid_reg;
    logic signed [LIMIT_W-1:0] out_cmd_reg;
    logic signed [STEER_W-1:0] out_steer_reg;
    logic                      out_clamped_reg;

    logic signed [ANGX_W-1:0]   ang_in;
    logic signed [ANGX_W-1:0]   ang_wrap;
    logic signed [DV_W-1:0]     dv_in;
    logic [GAIN_W-1:0]          ki;
    logic signed [RATE_X_W-1:0] rate_x;
    logic [RL_W-1:0]            rate_lo;
    logic signed [RH_W-1:0]     rate_hi;
    logic signed [MA_W-1:0]     mul_a;
    logic signed [MB_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_sh;
    logic signed [PROD_W:0]     prod_neg;
    logic signed [PROD_W:0]     neg_sh;
    logic signed [CMD_W-1:0]    cmd_kp;
    logic signed [CMD_W-1:0]    cmd_ki;
    logic signed [CMD_W-1:0]    max_x;
    logic signed [CMD_W-1:0]    min_x;
    logic signed [CMD_W-1:0]    cmd_hi_clamp;
    logic signed [CMD_W-1:0]    cmd_clamped;
    logic signed [SUMX_W-1:0]   sum_add;
    logic signed [SUMX_W-1:0]   lim_pos;
    logic signed [SUMX_W-1:0]   sum_bound;
    logic signed [DIFF_W-1:0]   diff_new;
    logic signed [ACC_W-1:0]    acc_hi;
    logic signed [S_W-1:0]      s_full;
    logic signed [S_W-1:0]      s_bound;
    logic                       finish_fire;

    // Heading is folded back by one turn at most.
    assign ang_in = ANGX_W'(heading_error);
    always_comb
    begin
        priority if (ang_in < -PI1_A)
        begin
            ang_wrap = ang_in + PI2_A;
        end
        else if (ang_in > PI1_A)
        begin
            ang_wrap = ang_in - PI2_A;
        end
        else
        begin
            ang_wrap = ang_in;
        end
    end

    assign dv_in   = DV_W'(measured_speed) - DV_W'(speed_target);
    assign ki      = ioff_reg ? '0 : {2'b00, speed_gain_reg[GAIN_W-1:2]};
    assign rate_x  = RATE_X_W'(rate_reg);
    assign rate_lo = rate_x[RL_W-1:0];
    assign rate_hi = rate_x[RATE_X_W-1:RL_W];

    always_comb
    begin
        unique case (cmd.mul_sel)
            SEL_KP_DV:
            begin
                mul_a = {1'b0, speed_gain_reg};
                mul_b = MB_W'(dv_reg);
            end
            SEL_KI_SUM:
            begin
                mul_a = {1'b0, ki};
                mul_b = MB_W'(sum_reg);
            end
            SEL_DT_DV:
            begin
                mul_a = MA_W'(tick_period_reg);
                mul_b = MB_W'(dv_reg);
            end
            SEL_KI_INC:
            begin
                mul_a = {1'b0, ki};
                mul_b = MB_W'(inc_reg);
            end
            SEL_AIM_ANG:
            begin
                mul_a = {1'b0, aim_gain_reg};
                mul_b = MB_W'(ang_reg);
            end
            SEL_COEF_DIFF:
            begin
                mul_a = {1'b0, filter_coef_reg};
                mul_b = MB_W'(diff_reg);
            end
            SEL_DT_RLO:
            begin
                mul_a = MA_W'(tick_period_reg);
                mul_b = MB_W'(rate_lo);
            end
            SEL_DT_RHI:
            begin
                mul_a = MA_W'(tick_period_reg);
                mul_b = MB_W'(rate_hi);
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // Arithmetic right shifts round toward minus infinity.
    assign prod_sh  = prod_reg >>> FRAC_BITS;
    assign prod_neg = -{prod_reg[PROD_W-1], prod_reg};
    assign neg_sh   = prod_neg >>> FRAC_BITS;
    assign cmd_kp   = cmd_reg + CMD_W'(neg_sh);
    assign cmd_ki   = cmd_reg - CMD_W'(prod_sh);

    assign max_x = CMD_W'(accel_max_reg);
    assign min_x = CMD_W'(accel_min_reg);
    assign status.in_limits = (cmd_reg < max_x) && (cmd_reg > min_x);
    assign status.out_free  = !out_valid_reg || out_ready;

    assign cmd_hi_clamp = (cmd_reg > max_x) ? max_x : cmd_reg;
    assign cmd_clamped  = (cmd_hi_clamp < min_x) ? min_x : cmd_hi_clamp;

    assign sum_add = SUMX_W'(sum_reg) + SUMX_W'(inc_reg);
    assign lim_pos = SUMX_W'(sum_limit_reg);
    always_comb
    begin
        priority if (sum_add > lim_pos)
        begin
            sum_bound = lim_pos;
        end
        else if (sum_add < -lim_pos)
        begin
            sum_bound = -lim_pos;
        end
        else
        begin
            sum_bound = sum_add;
        end
    end

    assign diff_new = DIFF_W'(prod_sh) - DIFF_W'(steer_reg);
    assign acc_hi   = acc_reg + (ACC_W'(prod_reg) <<< RL_W);
    assign s_full   = S_W'(steer_reg) + S_W'(acc_reg >>> FRAC_BITS);

    // A filtered angle beyond three half turns is replaced by a fixed angle.
    always_comb
    begin
        priority if (s_full > PI3_S)
        begin
            s_bound = K93_S;
        end
        else if (s_full < -PI3_S)
        begin
            s_bound = -K93_S;
        end
        else
        begin
            s_bound = s_full;
        end
    end

    assign finish_fire = (cmd.acc == ACC_FINISH) && status.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_gain_reg  <= '0;
            accel_max_reg   <= '0;
            accel_min_reg   <= '0;
            sum_limit_reg   <= '0;
            aim_gain_reg    <= '0;
            filter_coef_reg <= '0;
            tick_period_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SPEED_GAIN:  speed_gain_reg  <= cfg_data[GAIN_W-1:0];
                CFG_ACCEL_MAX:   accel_max_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_ACCEL_MIN:   accel_min_reg   <= cfg_data[LIMIT_W-1:0];
                CFG_SUM_LIMIT:   sum_limit_reg   <= cfg_data[GAIN_W-1:0];
                CFG_AIM_GAIN:    aim_gain_reg    <= cfg_data[GAIN_W-1:0];
                CFG_FILTER_COEF: filter_coef_reg <= cfg_data[GAIN_W-1:0];
                CFG_TICK_PERIOD: tick_period_reg <= cfg_data[DT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            steer_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc == ACC_KII)
            begin
                sum_reg <= SUM_W'(sum_bound);
            end
            if (finish_fire)
            begin
                steer_reg     <= STEER_W'(s_bound);
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cmd.load)
        begin
            dv_reg   <= dv_in;
            ang_reg  <= ang_wrap;
            ioff_reg <= integral_off;
            cmd_reg  <= CMD_W'(accel_feedforward);
        end
        unique case (cmd.acc)
            ACC_NONE:
            begin
            end
            ACC_KP:   cmd_reg <= cmd_kp;
            ACC_KIS:  cmd_reg <= cmd_ki;
            ACC_INC:
            begin
                inc_reg    <= INC_W'(prod_sh);
                inside_reg <= status.in_limits;
            end
            ACC_KII:  cmd_reg  <= cmd_ki;
            ACC_UNF:  diff_reg <= diff_new;
            ACC_RATE: rate_reg <= RATE_W'(prod_sh);
            ACC_RLO:  acc_reg  <= ACC_W'(prod_reg);
            ACC_RHI:  acc_reg  <= acc_hi;
            ACC_FINISH:
            begin
                if (status.out_free)
                begin
                    out_cmd_reg     <= LIMIT_W'(cmd_clamped);
                    out_steer_reg   <= STEER_W'(s_bound);
                    out_clamped_reg <= !inside_reg;
                end
            end
        endcase
    end

    assign out_valid     = out_valid_reg;
    assign accel_command = out_cmd_reg;
    assign steer_angle   = out_steer_reg;
    assign accel_clamped = out_clamped_reg;

endmodule

### src/vehicle_pi_speed_and_steer_control.sv
`timescale 1ns / 1ps

// PI speed and steering controller for one control tick per request, in signed
// fixed point with 16 fraction bits. A request carries measured speed, target
// speed, feed-forward acceleration, heading error and an integral-off flag, and
// gives one result: the clamped acceleration command, the filtered steering
// angle and a flag that the command reached a limit. All products go through
// one shared 24 by 30 bit multiplier with a registered product; the operands
// of each product are selected in a MUL state and the registered product is
// then taken up by the matching ACC state. The integral update is skipped when
// the command is at or past a limit, and the finish step waits until the output
// register is free. The output is registered, so the next request is taken while
// a result still waits. The configuration registers should be written only while no request is in work.
module vehicle_pi_speed_and_steer_control (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // measured_speed, speed_target, accel_feedforward, heading_error.
    input  logic [vpssc_pkg::IN_DATA_W-1:0]      s_tdata,
    // integral_off.
    input  logic                                 s_tuser,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // accel_command, steer_angle.
    output logic [vpssc_pkg::OUT_DATA_W-1:0]     m_tdata,
    // accel_clamped.
    output logic                                 m_tuser,
    input  logic                                 cfg_we,
    input  logic [vpssc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [vpssc_pkg::CFG_W-1:0]          cfg_data
);
    import vpssc_pkg::*;

    `include "vehicle_pi_speed_and_steer_control_assert.svh"

    localparam logic signed [STEER_W-1:0] STEER_LIMIT = STEER_W'(PI3_Q);

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    logic signed [SPEED_W-1:0] measured_speed;
    logic signed [SPEED_W-1:0] speed_target;
    logic signed [SPEED_W-1:0] accel_feedforward;
    logic signed [ANG_W-1:0]   heading_error;
    logic signed [LIMIT_W-1:0] accel_command;
    logic signed [STEER_W-1:0] steer_angle;
    logic                      accel_clamped;

    assign measured_speed    = s_tdata[23:0];
    assign speed_target      = s_tdata[47:24];
    assign accel_feedforward = s_tdata[71:48];
    assign heading_error     = s_tdata[92:72];

    vpssc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    vpssc_datapath u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (dp_cmd),
        .status            (dp_status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .measured_speed    (measured_speed),
        .speed_target      (speed_target),
        .accel_feedforward (accel_feedforward),
        .integral_off      (s_tuser),
        .heading_error     (heading_error),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .accel_command     (accel_command),
        .steer_angle       (steer_angle),
        .accel_clamped     (accel_clamped)
    );

    assign m_tdata = {3'b000, steer_angle, accel_command};
    assign m_tuser = accel_clamped;

    `VPSSC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "request accepted while busy")
    `VPSSC_ASSERT(a_result_from_finish, $rose(m_tvalid) |-> $past(dp_cmd.acc == ACC_FINISH), "result without finish step")
    `VPSSC_ASSERT(a_steer_in_range, m_tvalid |-> (($signed(m_tdata[44:24]) <= STEER_LIMIT) && ($signed(m_tdata[44:24]) >= -STEER_LIMIT)), "steering angle out of range")

endmodule
